// File: design/assert_macros.svh
// assertion macros for the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHECK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CHECK(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/mf2d_pkg.sv
// shared types, constants and helpers of the median filter
package mf2d_pkg;
    localparam int DATA_W = 16;
    localparam int KS_W = 3;
    localparam int DIM_W = 13;
    localparam int CFG_IDX_W = 2;
    localparam int H_W = 2;

    localparam int DEF_MAX_KERNEL = 5;
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [KS_W-1:0] RST_KERNEL = KS_W'(3);
    localparam logic [DIM_W-1:0] RST_WIDTH = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(2);

    typedef struct packed {
        logic           live;
        logic           done;
        logic           emit;
        logic           interior;
        logic           frame_end;
        logic [H_W-1:0] h;
    } info_t;

    function automatic int median_target(input logic [H_W-1:0] h);
        int hv;
        hv = int'(h);
        return 2 * hv * (hv + 1);
    endfunction
endpackage

// File: design/median_filter_2d_unit.sv
// top level of the streaming square-window median filter
//
// input channel s_*: one transfer per pixel in raster order (s_action 0) or
// a flush tick (s_action 1) that pushes out a pending result after the frame.
// output channel m_*: filtered pixels in raster order, m_frame_end on the last.
// configuration: cfg_we writes cfg_wdata into register cfg_addr (0 kernel
// size, 1 frame width, 2 frame height); each of these restarts the frame.
// throughput: one input transfer per cycle while s_ready is high, set by the
// single line store read and write-back of one column per pixel.
// a result passes the input, window and median a, b, c registers on its way
// to m_valid; output lags input by h rows plus h pixels, h = k/2.
// the line store holds no reset; stale entries only feed border pixels.
// reset clears the counters, the window and the pipeline valid flags.
// a stalled receiver fills the five pipeline stages, then s_ready drops;
// bubbles from items that give no result are squeezed out meanwhile.
module median_filter_2d_unit import mf2d_pkg::*; #(
    parameter int MAX_KERNEL = DEF_MAX_KERNEL,
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [DATA_W-1:0]    s_pixel_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_pixel_out,
    output logic                 m_frame_end
);
    localparam int HALF_MAX = MAX_KERNEL / 2;
    localparam int LINES = 2 * HALF_MAX;
    localparam int SIDE = LINES + 1;
    localparam int N = SIDE * SIDE;
    localparam int COL_W = $clog2(MAX_WIDTH);

    typedef logic [LINES-1:0][DATA_W-1:0] word_t;

    info_t               info, info1_reg, info2_reg;
    logic [COL_W-1:0]    col_addr, addr1_reg;
    logic                accept, live_acc, move1, rdy1, rdy2, med_ready;
    logic                v1_reg, v2_reg, fwd_reg;
    logic [DATA_W-1:0]   val1_reg, val_in;
    word_t               fwd_word_reg, ram_rdata, word_cur, wr_word;
    logic [SIDE-1:0][DATA_W-1:0] col_vec;
    logic [SIDE-1:0][SIDE-1:0][DATA_W-1:0] win_reg;
    logic [N-1:0][DATA_W-1:0] win_flat;

    mf2d_seq #(
        .MAX_KERNEL(MAX_KERNEL),
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_seq (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .accept(accept),
        .action(s_action),
        .info(info),
        .col_addr(col_addr)
    );

    assign rdy2 = !v2_reg || med_ready;
    assign rdy1 = !v1_reg || rdy2;
    assign move1 = v1_reg && rdy2;
    assign s_ready = rdy1;
    assign accept = s_valid && s_ready;
    assign live_acc = accept && info.live;
    assign val_in = info.done ? '0 : s_pixel_in;

    mf2d_ram #(
        .WIDTH(LINES * DATA_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .aclk(aclk),
        .we(move1),
        .waddr(addr1_reg),
        .wdata(wr_word),
        .re(live_acc),
        .raddr(col_addr),
        .rdata(ram_rdata)
    );

    assign word_cur = fwd_reg ? fwd_word_reg : ram_rdata;

    always_comb begin
        col_vec[0] = val1_reg;
        for (int k = 1; k < SIDE; k++) begin
            col_vec[k] = word_cur[k-1];
        end
        for (int k = 0; k < LINES; k++) begin
            wr_word[k] = col_vec[k];
        end
        for (int k = 0; k < SIDE; k++) begin
            for (int j = 0; j < SIDE; j++) begin
                win_flat[k * SIDE + j] = win_reg[k][j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            fwd_reg <= 1'b0;
            win_reg <= '0;
        end else begin
            if (live_acc) begin
                v1_reg <= 1'b1;
                fwd_reg <= move1 && (addr1_reg == col_addr);
            end else if (move1) begin
                v1_reg <= 1'b0;
            end
            if (move1) begin
                v2_reg <= info1_reg.emit;
                for (int k = 0; k < SIDE; k++) begin
                    for (int j = 0; j < LINES; j++) begin
                        win_reg[k][j] <= win_reg[k][j+1];
                    end
                    win_reg[k][LINES] <= col_vec[k];
                end
            end else if (v2_reg && med_ready) begin
                v2_reg <= 1'b0;
            end
        end
        if (live_acc) begin
            addr1_reg <= col_addr;
            val1_reg <= val_in;
            info1_reg <= info;
            fwd_word_reg <= wr_word;
        end
        if (move1) begin
            info2_reg <= info1_reg;
        end
    end

    mf2d_median #(
        .MAX_KERNEL(MAX_KERNEL)
    ) u_median (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(v2_reg),
        .in_ready(med_ready),
        .window(win_flat),
        .h(info2_reg.h),
        .interior(info2_reg.interior),
        .frame_end(info2_reg.frame_end),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .pixel_out(m_pixel_out),
        .out_frame_end(m_frame_end)
    );
endmodule

// File: design/mf2d_ram.sv
// generic single-port-write, registered-read ram
module mf2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: design/mf2d_seq.sv
// configuration registers and frame position counters
module mf2d_seq import mf2d_pkg::*; #(
    parameter int MAX_KERNEL = DEF_MAX_KERNEL,
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_addr,
    input  logic [DIM_W-1:0]             cfg_wdata,
    input  logic                         accept,
    input  logic                         action,
    output info_t                        info,
    output logic [$clog2(MAX_WIDTH)-1:0] col_addr
);
    localparam int HALF_MAX = MAX_KERNEL / 2;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int OROW_W = $clog2(MAX_HEIGHT);
    localparam int ROW_W = OROW_W + 2;
    localparam int EXT_W = 16;
    localparam int PROD_W = 32;

    logic [KS_W-1:0]   ks_reg, ks_next;
    logic [DIM_W-1:0]  fw_reg, fw_next, fh_reg, fh_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;

    logic [EXT_W-1:0] w_x, ht_x, h_x, in_col_x, in_row_x, out_col_x, out_row_x;
    logic [PROD_W-1:0] n_x, thr_x;
    logic [H_W-1:0]   h_raw, h;
    logic             restart;

    always_comb begin
        if (fw_reg == '0) begin
            w_x = EXT_W'(1);
        end else if (EXT_W'(fw_reg) > EXT_W'(MAX_WIDTH)) begin
            w_x = EXT_W'(MAX_WIDTH);
        end else begin
            w_x = EXT_W'(fw_reg);
        end
        if (fh_reg == '0) begin
            ht_x = EXT_W'(1);
        end else if (EXT_W'(fh_reg) > EXT_W'(MAX_HEIGHT)) begin
            ht_x = EXT_W'(MAX_HEIGHT);
        end else begin
            ht_x = EXT_W'(fh_reg);
        end
    end

    assign h_raw = ks_reg[KS_W-1:1];
    assign h = (h_raw > H_W'(HALF_MAX)) ? H_W'(HALF_MAX) : h_raw;
    assign h_x = EXT_W'(h);
    assign in_col_x = EXT_W'(in_col_reg);
    assign in_row_x = EXT_W'(in_row_reg);
    assign out_col_x = EXT_W'(out_col_reg);
    assign out_row_x = EXT_W'(out_row_reg);

    // raster index of the input and the index of the first result
    assign n_x = PROD_W'(in_row_x) * PROD_W'(w_x) + PROD_W'(in_col_x);
    assign thr_x = PROD_W'(h_x) * PROD_W'(w_x) + PROD_W'(h_x);

    always_comb begin
        info.h = h;
        info.done = in_row_x >= ht_x;
        info.live = !action || info.done;
        info.emit = n_x >= thr_x;
        info.interior = out_row_x >= h_x && out_row_x + h_x < ht_x
                        && out_col_x >= h_x && out_col_x + h_x < w_x;
        info.frame_end = (out_row_x + EXT_W'(1) == ht_x) && (out_col_x + EXT_W'(1) == w_x);
    end

    assign col_addr = in_col_reg;

    always_comb begin
        ks_next = ks_reg;
        fw_next = fw_reg;
        fh_next = fh_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        restart = 1'b0;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_KERNEL: begin
                    ks_next = cfg_wdata[KS_W-1:0];
                    restart = 1'b1;
                end
                CFG_WIDTH: begin
                    fw_next = cfg_wdata;
                    restart = 1'b1;
                end
                CFG_HEIGHT: begin
                    fh_next = cfg_wdata;
                    restart = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (accept && info.live) begin
            if (in_col_x + EXT_W'(1) >= w_x) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (info.emit) begin
                if (out_col_x + EXT_W'(1) >= w_x) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
                if (info.frame_end) begin
                    restart = 1'b1;
                end
            end
        end
        if (restart) begin
            in_col_next = '0;
            in_row_next = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ks_reg <= RST_KERNEL;
            fw_reg <= RST_WIDTH;
            fh_reg <= RST_HEIGHT;
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            ks_reg <= ks_next;
            fw_reg <= fw_next;
            fh_reg <= fh_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end
endmodule

// File: design/mf2d_median.sv
// pipelined rank-select median over the active part of the window
`include "assert_macros.svh"
module mf2d_median import mf2d_pkg::*; #(
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [(2*(MAX_KERNEL/2)+1)**2-1:0][DATA_W-1:0] window,
    input  logic [H_W-1:0]                                h,
    input  logic                                          interior,
    input  logic                                          frame_end,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [DATA_W-1:0]                             pixel_out,
    output logic                                          out_frame_end
);
    localparam int HALF_MAX = MAX_KERNEL / 2;
    localparam int LINES = 2 * HALF_MAX;
    localparam int SIDE = LINES + 1;
    localparam int N = SIDE * SIDE;
    localparam int CNT_W = $clog2(N + 1);

    logic                      va_reg, vb_reg, vc_reg;
    logic                      rdy_a, rdy_b, rdy_c;
    logic [N-1:0]              active, act_a_reg;
    logic [N-1:0][N-1:0]       lt, lt_a_reg;
    logic [N-1:0][DATA_W-1:0]  vals_a_reg, vals_b_reg;
    logic [DATA_W-1:0]         border, border_a_reg, border_b_reg, result;
    logic [CNT_W-1:0]          tgt_a_reg;
    logic [H_W-1:0]            h_a_reg;
    logic                      int_a_reg, int_b_reg, fend_a_reg, fend_b_reg;
    logic [N-1:0]              sel, sel_b_reg;
    logic [2:0]                h2;

    assign rdy_c = !vc_reg || out_ready;
    assign rdy_b = !vb_reg || rdy_c;
    assign rdy_a = !va_reg || rdy_b;
    assign in_ready = rdy_a;
    assign h2 = {h, 1'b0};

    always_comb begin
        border = window[0];
        for (int q = 0; q <= HALF_MAX; q++) begin
            if (h == H_W'(q)) begin
                border = window[q * SIDE + LINES - q];
            end
        end
        for (int k = 0; k < SIDE; k++) begin
            for (int j = 0; j < SIDE; j++) begin
                active[k * SIDE + j] = (4'(k) <= 4'(h2)) && (4'(j) + 4'(h2) >= 4'(LINES));
            end
        end
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                lt[i][j] = active[j] && ((window[j] < window[i])
                           || (window[j] == window[i] && j < i));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            sel[i] = act_a_reg[i] && (CNT_W'($countones(lt_a_reg[i])) == tgt_a_reg);
        end
        result = '0;
        for (int i = 0; i < N; i++) begin
            result = result | (sel_b_reg[i] ? vals_b_reg[i] : '0);
        end
        if (!int_b_reg) begin
            result = border_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
            if (rdy_c) begin
                vc_reg <= vb_reg;
            end
        end
        if (rdy_a) begin
            act_a_reg <= active;
            lt_a_reg <= lt;
            vals_a_reg <= window;
            border_a_reg <= border;
            tgt_a_reg <= CNT_W'(median_target(h));
            h_a_reg <= h;
            int_a_reg <= interior;
            fend_a_reg <= frame_end;
        end
        if (rdy_b) begin
            sel_b_reg <= sel;
            vals_b_reg <= vals_a_reg;
            border_b_reg <= border_a_reg;
            int_b_reg <= int_a_reg;
            fend_b_reg <= fend_a_reg;
        end
        if (rdy_c) begin
            pixel_out <= result;
            out_frame_end <= fend_b_reg;
        end
    end

    assign out_valid = vc_reg;

    `ASSERT_IMPLY(a_sel_onehot, aclk, aresetn, vb_reg && int_b_reg, $onehot(sel_b_reg))
    `ASSERT_IMPLY(a_active_count, aclk, aresetn, va_reg,
        $countones(act_a_reg) == (2 * int'(h_a_reg) + 1) * (2 * int'(h_a_reg) + 1))
    `ASSERT_IMPLY(a_order_total, aclk, aresetn, va_reg && act_a_reg[0] && act_a_reg[1],
        lt_a_reg[0][1] != lt_a_reg[1][0])
endmodule
